// ----- hw/rtl/abp_pkg.sv -----
package abp_pkg;

   localparam int unsigned SizeBitsDefault = 32;

   typedef enum logic [2:0] {
      PH_COUNT   = 3'd0,
      PH_NAMELEN = 3'd1,
      PH_NAME    = 3'd2,
      PH_TYPE    = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_IDLE    = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      ROLE_COUNT    = 3'd0,
      ROLE_NAME_LEN = 3'd1,
      ROLE_NAME_CHR = 3'd2,
      ROLE_TYPE     = 3'd3,
      ROLE_PAY_LEN  = 3'd4,
      ROLE_PAY_DATA = 3'd5,
      ROLE_PAY_CHR  = 3'd6,
      ROLE_IGNORED  = 3'd7
   } role_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_TRUNCATED = 2'd1,
      ST_UNKNOWN   = 2'd2,
      ST_TRAILING  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      K_END   = 3'd0,
      K_LEN   = 3'd1,
      K_CNT   = 3'd2,
      K_CHARS = 3'd3,
      K_SEQ   = 3'd4,
      K_FIX   = 3'd5
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [5:0]  n;
   } seg_type;

   localparam logic [7:0] T_BOOL    = 8'h03;
   localparam logic [7:0] T_STRING  = 8'h02;
   localparam logic [7:0] T_FLOAT64 = 8'h06;
   localparam logic [7:0] T_ENUM    = 8'h15;
   localparam logic [7:0] T_NUMSEQ  = 8'h17;
   localparam logic [7:0] T_COLSEQ  = 8'h19;
   localparam logic [7:0] T_FONT    = 8'h21;

   function automatic logic known_type(input logic [7:0] t);
      logic k;
      unique case (t)
         8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h09, 8'h0A, 8'h0E, 8'h0F,
         8'h10, 8'h11, 8'h14, 8'h15, 8'h17, 8'h19, 8'h1B, 8'h1C, 8'h21: k = 1'b1;
         default: k = 1'b0;
      endcase
      return k;
   endfunction

   function automatic seg_type seg_kind(input logic [7:0] t, input logic [2:0] s);
      seg_type r;
      r.kind = K_END;
      r.n    = 6'd0;
      unique case (t)
         8'h02: begin
            if (s == 3'd0) r.kind = K_LEN;
            else if (s == 3'd1) r.kind = K_CHARS;
         end
         8'h03: if (s == 3'd0) begin r.kind = K_FIX; r.n = 6'd1; end
         8'h04, 8'h05, 8'h0E: if (s == 3'd0) begin r.kind = K_FIX; r.n = 6'd4; end
         8'h06, 8'h09, 8'h10, 8'h1B: if (s == 3'd0) begin r.kind = K_FIX; r.n = 6'd8; end
         8'h0F, 8'h11: if (s == 3'd0) begin r.kind = K_FIX; r.n = 6'd12; end
         8'h0A, 8'h1C: if (s == 3'd0) begin r.kind = K_FIX; r.n = 6'd16; end
         8'h14: if (s == 3'd0) begin r.kind = K_FIX; r.n = 6'd48; end
         8'h15: begin
            if (s == 3'd0) r.kind = K_LEN;
            else if (s == 3'd1) r.kind = K_CHARS;
            else if (s == 3'd2) begin r.kind = K_FIX; r.n = 6'd4; end
         end
         8'h17: begin
            if (s == 3'd0) begin r.kind = K_CNT; r.n = 6'd12; end
            else if (s == 3'd1) r.kind = K_SEQ;
         end
         8'h19: begin
            if (s == 3'd0) begin r.kind = K_CNT; r.n = 6'd20; end
            else if (s == 3'd1) r.kind = K_SEQ;
         end
         8'h21: begin
            if (s == 3'd0 || s == 3'd4) r.kind = K_LEN;
            else if (s == 3'd1 || s == 3'd5) r.kind = K_CHARS;
            else if (s == 3'd2) begin r.kind = K_FIX; r.n = 6'd2; end
            else if (s == 3'd3) begin r.kind = K_FIX; r.n = 6'd1; end
         end
         default: r.kind = K_END;
      endcase
      return r;
   endfunction

endpackage

// ----- hw/rtl/attribute_blob_parser_top.sv -----
// channel | direction | beat contents
// req_    | in        | byte_value, blob_size, first_byte
// rsp_    | out       | byte_out, role, type_id, record_index, field_end, record_end,
//         |           | status, blob_done
// one beat in, one beat out; a beat is parsed in the cycle it is accepted and its
// result is registered for the next cycle; a new beat enters each unstalled cycle
// the rate is set by the single parse step from state registers to output register
// reset clears the parse state and empties the output register
// req_stall is high only while a result waits and rsp_stall holds it
module attribute_blob_parser_top #(
   parameter int unsigned SIZE_BITS = abp_pkg::SizeBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_value,
   input  logic [31:0] req_blob_size,
   input  logic        req_first_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_byte_out,
   output logic [2:0]  rsp_role,
   output logic [7:0]  rsp_type_id,
   output logic [31:0] rsp_record_index,
   output logic        rsp_field_end,
   output logic        rsp_record_end,
   output logic [1:0]  rsp_status,
   output logic        rsp_blob_done
);

   localparam int unsigned PW = 38;

   abp_pkg::phase_type    ph_ff, ph_in;
   logic [2:0]            seg_ff, seg_in;
   logic [31:0]           fbl_ff, fbl_in;
   logic [31:0]           lsh_ff, lsh_in;
   logic [31:0]           rl_ff, rl_in;
   logic [31:0]           rc_ff, rc_in;
   logic [SIZE_BITS-1:0]  bp_ff, bp_in;
   logic [SIZE_BITS-1:0]  sz_ff, sz_in;
   logic [7:0]            ct_ff, ct_in;
   abp_pkg::status_type   err_ff, err_in;

   logic                  rsp_valid_ff;
   logic [7:0]            byte_ff;
   abp_pkg::role_type     role_ff, role_in;
   logic [7:0]            type_ff, type_in;
   logic [31:0]           idx_ff, idx_in;
   logic                  fe_ff, fe_in;
   logic                  re_ff, re_in;
   logic                  done_ff, done_in;

   logic                  accept;
   abp_pkg::seg_type      sk, sk2;
   logic [SIZE_BITS-1:0]  rem;
   logic [PW-1:0]         rem_w;
   logic [PW-1:0]         total;
   logic                  do_enter, do_start, do_open, do_finish, do_fail;
   logic [2:0]            eseg;
   abp_pkg::phase_type    open_ph;
   logic [5:0]            open_len;
   abp_pkg::status_type   fail_code;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      ph_in  = ph_ff;  seg_in = seg_ff; fbl_in = fbl_ff; lsh_in = lsh_ff;
      rl_in  = rl_ff;  rc_in  = rc_ff;  bp_in  = bp_ff;  sz_in  = sz_ff;
      ct_in  = ct_ff;  err_in = err_ff;
      role_in = abp_pkg::ROLE_IGNORED;
      type_in = 8'd0; idx_in = 32'd0; fe_in = 1'b0; re_in = 1'b0; done_in = 1'b0;
      do_enter = 1'b0; do_start = 1'b0; do_open = 1'b0; do_finish = 1'b0; do_fail = 1'b0;
      eseg = 3'd0; open_ph = abp_pkg::PH_TYPE; open_len = 6'd0;
      fail_code = abp_pkg::ST_TRUNCATED; total = '0;
      sk = '0; sk2 = '0; rem = '0; rem_w = '0;
      if (req_first_byte) begin
         ph_in = abp_pkg::PH_COUNT; seg_in = 3'd0; fbl_in = 32'd4; lsh_in = 32'd0;
         rl_in = 32'd0; rc_in = 32'd0; bp_in = '0; sz_in = req_blob_size[SIZE_BITS-1:0];
         ct_in = 8'd0; err_in = abp_pkg::ST_OK;
      end
      if (ph_in == abp_pkg::PH_COUNT && bp_in == '0 && sz_in < SIZE_BITS'(4)) begin
         role_in = abp_pkg::ROLE_COUNT;
         do_fail = 1'b1;
      end else if (ph_in != abp_pkg::PH_IDLE) begin
         sk = abp_pkg::seg_kind(ct_in, seg_in);
         unique case (ph_in)
            abp_pkg::PH_COUNT:   role_in = abp_pkg::ROLE_COUNT;
            abp_pkg::PH_NAMELEN: role_in = abp_pkg::ROLE_NAME_LEN;
            abp_pkg::PH_NAME:    role_in = abp_pkg::ROLE_NAME_CHR;
            abp_pkg::PH_TYPE:    role_in = abp_pkg::ROLE_TYPE;
            abp_pkg::PH_PAYLOAD: begin
               if (sk.kind == abp_pkg::K_LEN || sk.kind == abp_pkg::K_CNT)
                  role_in = abp_pkg::ROLE_PAY_LEN;
               else if (sk.kind == abp_pkg::K_CHARS) role_in = abp_pkg::ROLE_PAY_CHR;
               else role_in = abp_pkg::ROLE_PAY_DATA;
            end
            abp_pkg::PH_IDLE:    role_in = abp_pkg::ROLE_IGNORED;
         endcase
         type_in = (ph_in == abp_pkg::PH_TYPE) ? req_byte_value : ct_in;
         idx_in  = (ph_in == abp_pkg::PH_COUNT) ? 32'd0 : rc_in;
         lsh_in  = {req_byte_value, lsh_in[31:8]};
         bp_in   = bp_in + SIZE_BITS'(1);
         fbl_in  = fbl_in - 32'd1;
         rem     = (bp_in <= sz_in) ? sz_in - bp_in : '0;
         rem_w   = PW'(rem);
         fe_in   = (fbl_in == 32'd0);
         if (role_in == abp_pkg::ROLE_PAY_DATA && ct_in != abp_pkg::T_BOOL &&
             ct_in != abp_pkg::T_FLOAT64 && ct_in != abp_pkg::T_FONT &&
             fbl_in[1:0] == 2'd0)
            fe_in = 1'b1;
         if (fbl_in == 32'd0) begin
            unique case (ph_in)
               abp_pkg::PH_COUNT: begin
                  rl_in = lsh_in;
                  if ((PW'(lsh_in) << 2) + PW'(lsh_in) > rem_w) do_fail = 1'b1;
                  else if (lsh_in == 32'd0) do_finish = 1'b1;
                  else do_start = 1'b1;
               end
               abp_pkg::PH_NAMELEN: begin
                  if (PW'(lsh_in) > rem_w) do_fail = 1'b1;
                  else if (lsh_in == 32'd0) begin
                     do_open = 1'b1; open_ph = abp_pkg::PH_TYPE; open_len = 6'd1;
                  end else begin
                     ph_in = abp_pkg::PH_NAME; fbl_in = lsh_in;
                  end
               end
               abp_pkg::PH_NAME: begin
                  do_open = 1'b1; open_ph = abp_pkg::PH_TYPE; open_len = 6'd1;
               end
               abp_pkg::PH_TYPE: begin
                  if (!abp_pkg::known_type(req_byte_value)) begin
                     do_fail = 1'b1; fail_code = abp_pkg::ST_UNKNOWN;
                  end else begin
                     ct_in = req_byte_value; do_enter = 1'b1; eseg = 3'd0;
                  end
               end
               abp_pkg::PH_PAYLOAD: begin
                  if (sk.kind == abp_pkg::K_LEN || sk.kind == abp_pkg::K_CNT) begin
                     // element sizes are 12 or 20 bytes: 4x plus 8x or 16x
                     if (sk.kind == abp_pkg::K_CNT)
                        total = (PW'(lsh_in) << 2) + ((sk.n == 6'd12) ?
                                (PW'(lsh_in) << 3) : (PW'(lsh_in) << 4));
                     else
                        total = PW'(lsh_in);
                     if (total > rem_w) do_fail = 1'b1;
                     else if (total == '0) begin
                        do_enter = 1'b1; eseg = seg_in + 3'd2;
                     end else begin
                        seg_in = seg_in + 3'd1; fbl_in = total[31:0];
                     end
                  end else begin
                     do_enter = 1'b1; eseg = seg_in + 3'd1;
                  end
               end
               abp_pkg::PH_IDLE: ;
            endcase
         end
         if (do_enter) begin
            sk2 = abp_pkg::seg_kind(ct_in, eseg);
            seg_in = eseg;
            if (sk2.kind == abp_pkg::K_END) begin
               re_in = 1'b1;
               rl_in = rl_in - 32'd1;
               rc_in = rc_in + 32'd1;
               if (rl_in == 32'd0) do_finish = 1'b1;
               else do_start = 1'b1;
            end else begin
               do_open = 1'b1; open_ph = abp_pkg::PH_PAYLOAD;
               open_len = (sk2.kind == abp_pkg::K_LEN || sk2.kind == abp_pkg::K_CNT) ?
                          6'd4 : sk2.n;
            end
         end
         if (do_start) begin
            ct_in = 8'd0;
            do_open = 1'b1; open_ph = abp_pkg::PH_NAMELEN; open_len = 6'd4;
         end
         if (do_open) begin
            ph_in = open_ph;
            if (PW'(open_len) > rem_w) do_fail = 1'b1;
            else fbl_in = 32'(open_len);
         end
         if (do_finish) begin
            ph_in = abp_pkg::PH_IDLE; done_in = 1'b1;
            if (rem != '0) err_in = abp_pkg::ST_TRAILING;
         end
      end
      if (do_fail) begin
         err_in = fail_code; ph_in = abp_pkg::PH_IDLE; done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= abp_pkg::PH_COUNT; seg_ff <= 3'd0; fbl_ff <= 32'd4; lsh_ff <= 32'd0;
         rl_ff <= 32'd0; rc_ff <= 32'd0; bp_ff <= '0; sz_ff <= '0; ct_ff <= 8'd0;
         err_ff <= abp_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            ph_ff <= ph_in; seg_ff <= seg_in; fbl_ff <= fbl_in; lsh_ff <= lsh_in;
            rl_ff <= rl_in; rc_ff <= rc_in; bp_ff <= bp_in; sz_ff <= sz_in;
            ct_ff <= ct_in; err_ff <= err_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_byte_value; role_ff <= role_in; type_ff <= type_in;
         idx_ff <= idx_in; fe_ff <= fe_in; re_ff <= re_in; done_ff <= done_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_byte_out     = byte_ff;
   assign rsp_role         = role_ff;
   assign rsp_type_id      = type_ff;
   assign rsp_record_index = idx_ff;
   assign rsp_field_end    = fe_ff;
   assign rsp_record_end   = re_ff;
   assign rsp_status       = err_ff;
   assign rsp_blob_done    = done_ff;

endmodule
